@@ sv/chained_hash_table_pool_core_defines.svh @@
// ----------------------------------------------------------------------------
// chained hash table pool core: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_POOL_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_POOL_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define CHTP_ASSERT_NOW(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("chtp port check failed");

// condition implies consequence in the next cycle
`define CHTP_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("chtp port check failed");

`endif

@@ sv/chtp_pkg.sv @@
// ----------------------------------------------------------------------------
// chtp_pkg
// types, codes and constants shared by the chained hash table pool core
// ----------------------------------------------------------------------------
`default_nettype none

package chtp_pkg;

	// default sizes
	localparam int NODES_DEF   = 255;
	localparam int BUCKETS_DEF = 1024;
	localparam int ENTRY_W_DEF = 32;

	// fixed port widths
	localparam int KEY_W        = 32;
	localparam int ENTRY_PORT_W = 32;
	localparam int CFG_W        = 11;
	localparam int ACT_W        = 2;
	localparam int STAT_W       = 2;
	localparam int KEY_CNT_W    = $clog2(KEY_W);
	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1021;

	// actions
	typedef enum logic [ACT_W-1:0] {
		ACT_FIND   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	// result codes
	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_DIV,
		ST_HEAD_RD,
		ST_HEAD_CHK,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_TAIL_RD,
		ST_TAIL_CHK,
		ST_DEL_A,
		ST_DEL_B,
		ST_DONE
	} state_t;

	// modulo unit request and response
	typedef struct packed {
		logic             start;
		logic [KEY_W-1:0] dividend;
		logic [CFG_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [CFG_W-1:0] rem;
	} mod_rsp_t;

	// finished result towards the output register
	typedef struct packed {
		logic              valid;
		logic [STAT_W-1:0] status;
	} res_t;

endpackage

`default_nettype wire

@@ sv/chained_hash_table_pool_core.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_pool_core
// hash table with separate chaining over a fixed node pool
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   action, key_hash, entry_data
// result    out        out_valid / out_stall status
// config    in         cfg_valid / cfg_ready bucket_count
//
// an item runs through the bit-serial remainder unit (32 steps and the
// done flag) and the head read, then a read and a check per chain node
// visited or per pool slot scanned, then the link updates and the result
// beat; one item is in work at a time
// reset and clear sweep the bucket heads and in-use flags, one entry per cycle
// over max(BUCKETS, NODES + 1) entries (1024 by default); no item is taken then
// a finished result sits in the output register while the next item enters
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_table_pool_core #(
	parameter int NODES       = chtp_pkg::NODES_DEF,
	parameter int BUCKETS     = chtp_pkg::BUCKETS_DEF,
	parameter int ENTRY_WIDTH = chtp_pkg::ENTRY_W_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [chtp_pkg::ACT_W-1:0]        action,
	input  wire logic [chtp_pkg::KEY_W-1:0]        key_hash,
	input  wire logic [chtp_pkg::ENTRY_PORT_W-1:0] entry_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [chtp_pkg::STAT_W-1:0]            status,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [chtp_pkg::CFG_W-1:0]        bucket_count
);
	import chtp_pkg::*;

	localparam logic [CFG_W-1:0] BUCKET_CAP =
		CFG_W'((BUCKETS > (2**CFG_W - 1)) ? (2**CFG_W - 1) : BUCKETS);

	logic [CFG_W-1:0]  bcount_q;
	logic [CFG_W-1:0]  divisor;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic              res_ready;
	mod_req_t          mod_req;
	mod_rsp_t          mod_rsp;
	res_t              res;

	// bucket count register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcount_q <= CFG_RESET;
		end else if (cfg_valid) begin
			bcount_q <= bucket_count;
		end
	end

	// effective bucket count, zero taken as one, capped at the table size
	always_comb begin
		if (bcount_q == '0) divisor = CFG_W'(1);
		else if (bcount_q > BUCKET_CAP) divisor = BUCKET_CAP;
		else divisor = bcount_q;
	end

	chtp_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	chtp_ctrl #(
		.NODES   (NODES),
		.BUCKETS (BUCKETS),
		.ENTRY_W (ENTRY_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.key_hash   (key_hash),
		.entry_data (entry_data),
		.divisor    (divisor),
		.mod_req    (mod_req),
		.mod_rsp    (mod_rsp),
		.res        (res),
		.res_ready  (res_ready)
	);

	// output register, one result beat
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) status_q <= res.status;
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

endmodule

`default_nettype wire

@@ sv/chtp_mod_unit.sv @@
// ----------------------------------------------------------------------------
// chtp_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module chtp_mod_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire chtp_pkg::mod_req_t req,
	output chtp_pkg::mod_rsp_t     rsp
);
	import chtp_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [KEY_CNT_W-1:0] cnt_q;
	logic [CFG_W-1:0]     rem_q;
	logic [KEY_W-1:0]     key_q;
	logic [CFG_W-1:0]     div_q;
	logic [CFG_W:0]       trial;
	logic                 ge;
	logic [CFG_W-1:0]     rem_nxt;

	// one restoring step
	assign trial   = {rem_q, key_q[KEY_W-1]};
	assign ge      = (trial >= {1'b0, div_q});
	assign rem_nxt = ge ? CFG_W'(trial - {1'b0, div_q}) : CFG_W'(trial);

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 1'b1;
			done_q <= (cnt_q == KEY_CNT_W'(KEY_W - 1));
			if (cnt_q == KEY_CNT_W'(KEY_W - 1)) begin
				busy_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// operand and remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			key_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			key_q <= {key_q[KEY_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

@@ sv/chtp_ctrl.sv @@
// ----------------------------------------------------------------------------
// chtp_ctrl
// sequencer and stores: bucket heads, node links, entries, in-use flags
// ----------------------------------------------------------------------------
`default_nettype none

module chtp_ctrl #(
	parameter int NODES   = chtp_pkg::NODES_DEF,
	parameter int BUCKETS = chtp_pkg::BUCKETS_DEF,
	parameter int ENTRY_W = chtp_pkg::ENTRY_W_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [chtp_pkg::ACT_W-1:0]      action,
	input  wire logic [chtp_pkg::KEY_W-1:0]      key_hash,
	input  wire logic [chtp_pkg::ENTRY_PORT_W-1:0] entry_data,
	input  wire logic [chtp_pkg::CFG_W-1:0]      divisor,
	output chtp_pkg::mod_req_t                   mod_req,
	input  wire chtp_pkg::mod_rsp_t              mod_rsp,
	output chtp_pkg::res_t                       res,
	input  wire logic                            res_ready
);
	import chtp_pkg::*;

	localparam int NW    = $clog2(NODES + 1);
	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SMAX  = (BUCKETS > NODES + 1) ? BUCKETS : NODES + 1;
	localparam int SW    = $clog2(SMAX);
	localparam logic [NW-1:0] NODES_N = NW'(NODES);
	localparam logic [NW-1:0] ONE_N   = NW'(1);

	// stores
	logic [NW-1:0]      head_mem  [2**BW];
	logic               use_mem   [2**NW];
	logic [NW-1:0]      next_mem  [2**NW];
	logic [NW-1:0]      prev_mem  [2**NW];
	logic [ENTRY_W-1:0] entry_mem [2**NW];

	// control registers
	state_t        state_q, state_nxt;
	logic [SW-1:0] sweep_q;
	logic          from_op_q;
	logic [NW-1:0] cursor_q;
	logic [NW-1:0] count_q;

	// working registers
	action_t            act_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [BW-1:0]      bucket_q;
	logic [NW-1:0]      head_q;
	logic [NW-1:0]      idx_q;
	logic [NW-1:0]      steps_q;
	logic [NW-1:0]      fresh_q;
	logic [NW-1:0]      p_q;
	logic [NW-1:0]      n_q;
	logic [STAT_W-1:0]  res_q;

	// read data
	logic [NW-1:0]      head_rd_q;
	logic               use_rd_q;
	logic [NW-1:0]      next_rd_q;
	logic [NW-1:0]      prev_rd_q;
	logic [ENTRY_W-1:0] entry_rd_q;

	// port controls
	logic [BW-1:0]      hr_addr;
	logic [NW-1:0]      nr_addr;
	logic               head_we;
	logic [BW-1:0]      head_wa;
	logic [NW-1:0]      head_wd;
	logic               use_we;
	logic [NW-1:0]      use_wa;
	logic               use_wd;
	logic               next_we;
	logic [NW-1:0]      next_wa;
	logic [NW-1:0]      next_wd;
	logic               prev_we;
	logic [NW-1:0]      prev_wa;
	logic [NW-1:0]      prev_wd;
	logic               entry_we;
	logic [NW-1:0]      entry_wa;

	// derived conditions
	logic          sweep_last;
	logic          hit;
	logic          tail_more;
	logic          walk_end;
	logic [NW-1:0] cur_norm;
	logic [NW-1:0] cur_nxt;
	logic          accept;

	function automatic logic node_ok(input logic [NW-1:0] x);
		node_ok = (x != '0) && (x <= NODES_N);
	endfunction

	assign accept     = (state_q == ST_IDLE) && in_valid;
	assign sweep_last = (sweep_q == SW'(SMAX - 1));
	assign hit        = use_rd_q && (entry_rd_q == entry_q);
	assign tail_more  = node_ok(next_rd_q) && (steps_q != NODES_N);
	assign walk_end   = !node_ok(idx_q) || (steps_q == NODES_N);
	assign cur_norm   = node_ok(cursor_q) ? cursor_q : ONE_N;
	assign cur_nxt    = (cur_norm >= NODES_N) ? ONE_N : cur_norm + 1'b1;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_SWEEP:    if (sweep_last) state_nxt = from_op_q ? ST_DONE : ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (action_t'(action) == ACT_CLEAR) ? ST_SWEEP : ST_DIV;
				end
			end
			ST_DIV:      if (mod_rsp.done) state_nxt = ST_HEAD_RD;
			ST_HEAD_RD:  state_nxt = ST_HEAD_CHK;
			ST_HEAD_CHK: state_nxt = (act_q == ACT_INSERT) ? ST_FREE_RD : ST_WALK_RD;
			ST_WALK_RD:  state_nxt = walk_end ? ST_DONE : ST_WALK_CHK;
			ST_WALK_CHK: begin
				if (hit) begin
					state_nxt = (act_q == ACT_DELETE) ? ST_DEL_A : ST_DONE;
				end else begin
					state_nxt = ST_WALK_RD;
				end
			end
			ST_FREE_RD:  state_nxt = (steps_q == NODES_N) ? ST_DONE : ST_FREE_CHK;
			ST_FREE_CHK: begin
				if (!use_rd_q) begin
					state_nxt = node_ok(head_q) ? ST_TAIL_RD : ST_DONE;
				end else begin
					state_nxt = ST_FREE_RD;
				end
			end
			ST_TAIL_RD:  state_nxt = ST_TAIL_CHK;
			ST_TAIL_CHK: state_nxt = tail_more ? ST_TAIL_RD : ST_DONE;
			ST_DEL_A:    state_nxt = ST_DEL_B;
			ST_DEL_B:    state_nxt = ST_DONE;
			ST_DONE:     if (res_ready) state_nxt = ST_IDLE;
			default:     state_nxt = ST_SWEEP;
		endcase
	end

	// store ports and handshake outputs
	always_comb begin
		hr_addr  = bucket_q;
		nr_addr  = idx_q;
		head_we  = 1'b0;
		head_wa  = bucket_q;
		head_wd  = '0;
		use_we   = 1'b0;
		use_wa   = fresh_q;
		use_wd   = 1'b0;
		next_we  = 1'b0;
		next_wa  = fresh_q;
		next_wd  = '0;
		prev_we  = 1'b0;
		prev_wa  = fresh_q;
		prev_wd  = '0;
		entry_we = 1'b0;
		entry_wa = fresh_q;
		res.valid  = 1'b0;
		res.status = res_q;
		case (state_q)
			ST_SWEEP: begin
				head_we = ({1'b0, sweep_q} < (SW + 1)'(BUCKETS));
				head_wa = sweep_q[BW-1:0];
				use_we  = ({1'b0, sweep_q} <= (SW + 1)'(NODES));
				use_wa  = sweep_q[NW-1:0];
			end
			ST_FREE_RD: nr_addr = cur_norm;
			ST_FREE_CHK: begin
				if (!use_rd_q) begin
					use_we   = 1'b1;
					use_wd   = 1'b1;
					entry_we = 1'b1;
					next_we  = 1'b1;
					if (!node_ok(head_q)) begin
						prev_we = 1'b1;
						head_we = 1'b1;
						head_wd = fresh_q;
					end
				end
			end
			ST_TAIL_CHK: begin
				if (!tail_more) begin
					prev_we = 1'b1;
					prev_wd = idx_q;
					next_we = 1'b1;
					next_wa = idx_q;
					next_wd = fresh_q;
				end
			end
			ST_DEL_A: begin
				if (node_ok(p_q)) begin
					next_we = 1'b1;
					next_wa = p_q;
					next_wd = n_q;
				end else if (head_q == idx_q) begin
					head_we = 1'b1;
					head_wd = n_q;
				end
				if (node_ok(n_q)) begin
					prev_we = 1'b1;
					prev_wa = n_q;
					prev_wd = p_q;
				end
				use_we = 1'b1;
				use_wa = idx_q;
			end
			ST_DEL_B: begin
				next_we = 1'b1;
				next_wa = idx_q;
				prev_we = 1'b1;
				prev_wa = idx_q;
			end
			ST_DONE: res.valid = 1'b1;
			default: ;
		endcase
	end

	assign in_stall         = (state_q != ST_IDLE);
	assign mod_req.start    = accept;
	assign mod_req.dividend = key_hash;
	assign mod_req.divisor  = divisor;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			sweep_q   <= '0;
			from_op_q <= 1'b0;
			cursor_q  <= ONE_N;
			count_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				from_op_q <= 1'b1;
				if (action_t'(action) == ACT_CLEAR) begin
					sweep_q  <= '0;
					cursor_q <= ONE_N;
					count_q  <= '0;
				end
			end
			if (state_q == ST_SWEEP && !sweep_last) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (state_q == ST_FREE_RD && steps_q != NODES_N) begin
				cursor_q <= cur_nxt;
			end
			// population count
			if (((state_q == ST_FREE_CHK) && !use_rd_q && !node_ok(head_q)) ||
				((state_q == ST_TAIL_CHK) && !tail_more)) begin
				if (count_q != NODES_N) count_q <= count_q + 1'b1;
			end else if (state_q == ST_DEL_B && count_q != '0) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					act_q   <= action_t'(action);
					entry_q <= ENTRY_W'(entry_data);
					res_q   <= STAT_OK;
				end
			end
			ST_DIV: if (mod_rsp.done) bucket_q <= BW'(mod_rsp.rem);
			ST_HEAD_CHK: begin
				head_q  <= head_rd_q;
				idx_q   <= head_rd_q;
				steps_q <= '0;
			end
			ST_WALK_RD: if (walk_end) res_q <= STAT_MISS;
			ST_WALK_CHK: begin
				if (hit) begin
					p_q <= prev_rd_q;
					n_q <= next_rd_q;
				end else begin
					idx_q   <= next_rd_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			ST_FREE_RD: begin
				if (steps_q == NODES_N) res_q <= STAT_FULL;
				else fresh_q <= cur_norm;
			end
			ST_FREE_CHK: begin
				if (use_rd_q) begin
					steps_q <= steps_q + 1'b1;
				end else begin
					idx_q   <= head_q;
					steps_q <= '0;
				end
			end
			ST_TAIL_CHK: begin
				if (tail_more) begin
					idx_q   <= next_rd_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// bucket head memory
	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[hr_addr];
	end

	// node memories, one shared read address
	always_ff @(posedge clk) begin
		if (use_we) use_mem[use_wa] <= use_wd;
		use_rd_q <= use_mem[nr_addr];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		next_rd_q <= next_mem[nr_addr];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		prev_rd_q <= prev_mem[nr_addr];
	end

	always_ff @(posedge clk) begin
		if (entry_we) entry_mem[entry_wa] <= entry_q;
		entry_rd_q <= entry_mem[nr_addr];
	end

endmodule

`default_nettype wire

@@ sv/chtp_checker.sv @@
// ----------------------------------------------------------------------------
// chtp_checker
// port-level checks on the chained hash table pool core
// ----------------------------------------------------------------------------
`default_nettype none

`include "chained_hash_table_pool_core_defines.svh"

module chtp_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [chtp_pkg::STAT_W-1:0] status
);
	import chtp_pkg::*;

	// a stalled result beat holds
	`CHTP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`CHTP_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(status))

	// an accepted beat occupies the block on the next cycle
	`CHTP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// only defined result codes leave the block
	`CHTP_ASSERT_NOW(a_status_code, clk, arst_n, out_valid,
		status == STAT_OK || status == STAT_MISS || status == STAT_FULL)

endmodule

bind chained_hash_table_pool_core chtp_checker u_chtp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status)
);

`default_nettype wire

@@ test/chained_hash_table_pool_core_tb.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_pool_core_tb
// drives find, insert, delete and clear beats into the hash table core and
// checks every status beat against a behavioural table kept in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module chained_hash_table_pool_core_tb;
	import chtp_pkg::*;

	localparam int NODES   = 255;
	localparam int BUCKETS = 1024;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	action_t                 action;
	logic [KEY_W-1:0]        key_hash;
	logic [ENTRY_PORT_W-1:0] entry_data;
	logic                    out_valid;
	logic                    out_stall;
	logic [STAT_W-1:0]       status;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_W-1:0]        bucket_count;

	chained_hash_table_pool_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .key_hash(key_hash), .entry_data(entry_data),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .bucket_count(bucket_count)
	);

	// mirror of the table
	logic [CFG_W-1:0] tbl_buckets;
	logic [7:0]       tbl_head [BUCKETS];
	logic             tbl_used [NODES+1];
	logic [7:0]       tbl_next [NODES+1];
	logic [7:0]       tbl_prev [NODES+1];
	logic [31:0]      tbl_entry [NODES+1];
	logic [7:0]       tbl_cursor;
	logic [STAT_W-1:0] status_due [$];
	int               fail_count;
	logic [31:0]      live_keys [$];
	logic [31:0]      live_vals [$];

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = 1'b1;
			#5 clk = 1'b0;
		end
	end

	function automatic int short_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	task automatic table_wipe();
		for (int i = 0; i < BUCKETS; i++)
			tbl_head[i] = '0;
		for (int i = 0; i <= NODES; i++) begin
			tbl_used[i] = 1'b0;
			tbl_next[i] = '0;
			tbl_prev[i] = '0;
			tbl_entry[i] = '0;
		end
		tbl_cursor = 8'd1;
	endtask

	function automatic int bucket_of(logic [31:0] key);
		int n;
		n = tbl_buckets;
		if (n == 0)
			n = 1;
		if (n > BUCKETS)
			n = BUCKETS;
		return key % n;
	endfunction

	function automatic int chain_lookup(int b, logic [31:0] ent);
		int idx;
		int steps;
		idx = tbl_head[b];
		steps = 0;
		while (idx != 0 && idx <= NODES && steps < NODES) begin
			if (tbl_used[idx] && tbl_entry[idx] == ent)
				return idx;
			idx = tbl_next[idx];
			steps++;
		end
		return 0;
	endfunction

	// expected status of one beat, updating the mirror
	task automatic table_apply(action_t act, logic [31:0] key, logic [31:0] ent,
			output logic [STAT_W-1:0] st);
		int b;
		int idx;
		int fresh;
		int tail;
		int steps;
		int p;
		int n;
		b = bucket_of(key);
		st = STAT_OK;
		case (act)
			ACT_FIND: begin
				st = chain_lookup(b, ent) != 0 ? STAT_OK : STAT_MISS;
			end
			ACT_INSERT: begin
				fresh = 0;
				for (int t = 0; t < NODES && fresh == 0; t++) begin
					idx = tbl_cursor;
					if (idx == 0 || idx > NODES)
						idx = 1;
					tbl_cursor = (idx >= NODES) ? 8'd1 : 8'(idx + 1);
					if (!tbl_used[idx]) begin
						tbl_used[idx] = 1'b1;
						fresh = idx;
					end
				end
				if (fresh == 0) begin
					st = STAT_FULL;
				end else begin
					tbl_entry[fresh] = ent;
					tbl_next[fresh] = '0;
					tail = tbl_head[b];
					if (tail == 0) begin
						tbl_prev[fresh] = '0;
						tbl_head[b] = 8'(fresh);
					end else begin
						steps = 0;
						while (tbl_next[tail] != 0 && steps < NODES) begin
							tail = tbl_next[tail];
							steps++;
						end
						tbl_prev[fresh] = 8'(tail);
						tbl_next[tail] = 8'(fresh);
					end
				end
			end
			ACT_DELETE: begin
				idx = chain_lookup(b, ent);
				if (idx == 0) begin
					st = STAT_MISS;
				end else begin
					p = tbl_prev[idx];
					n = tbl_next[idx];
					if (p != 0)
						tbl_next[p] = 8'(n);
					else if (tbl_head[b] == idx)
						tbl_head[b] = 8'(n);
					if (n != 0)
						tbl_prev[n] = 8'(p);
					tbl_used[idx] = 1'b0;
					tbl_next[idx] = '0;
					tbl_prev[idx] = '0;
				end
			end
			default: table_wipe();
		endcase
	endtask

	// send one beat and queue its expected status
	task automatic send_op(action_t act, logic [31:0] key, logic [31:0] ent);
		logic [STAT_W-1:0] st;
		repeat (1 + short_gap()) @(negedge clk);
		action <= act;
		key_hash <= key;
		entry_data <= ent;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		table_apply(act, key, ent, st);
		status_due.push_back(st);
		if (act == ACT_INSERT && st == STAT_OK) begin
			live_keys.push_back(key);
			live_vals.push_back(ent);
		end
		if (act == ACT_CLEAR) begin
			live_keys = {};
			live_vals = {};
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// wait until drained, then write the bucket count
	task automatic set_buckets(logic [CFG_W-1:0] val);
		while (status_due.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		bucket_count <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tbl_buckets = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result side: random stalls, compare each beat
	initial begin
		out_stall = 1'b1;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(0, 3) == 0) || ($urandom_range(0, 40) == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (status_due.size() == 0) begin
				$display("%0t: status %0d with none expected", $time, status);
				fail_count++;
			end else begin
				if (status !== status_due[0]) begin
					$display("%0t: status expected %0d actual %0d", $time,
						status_due[0], status);
					fail_count++;
				end
				void'(status_due.pop_front());
			end
		end
	end

	task automatic test_directed();
		send_op(ACT_FIND, 32'd0, 32'd0);
		send_op(ACT_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(ACT_INSERT, 32'd0, 32'd0);
		send_op(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(ACT_INSERT, 32'd1021, 32'hFFFF_FFFF);
		send_op(ACT_INSERT, 32'd0, 32'd0);
		send_op(ACT_FIND, 32'd0, 32'd0);
		send_op(ACT_FIND, 32'd1021, 32'hFFFF_FFFF);
		send_op(ACT_DELETE, 32'd0, 32'd0);
		send_op(ACT_FIND, 32'd0, 32'd0);
		send_op(ACT_DELETE, 32'd0, 32'd0);
		send_op(ACT_FIND, 32'd0, 32'd0);
		send_op(ACT_DELETE, 32'd1021, 32'hFFFF_FFFF);
		send_op(ACT_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(ACT_CLEAR, 32'hFFFF_FFFF, 32'h0);
		send_op(ACT_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	// fill the pool past capacity, then free middle nodes, insert again and clear
	task automatic test_pool_full();
		for (int i = 0; i < NODES + 2; i++)
			send_op(ACT_INSERT, $urandom, $urandom);
		send_op(ACT_DELETE, live_keys[7], live_vals[7]);
		send_op(ACT_DELETE, live_keys[100], live_vals[100]);
		send_op(ACT_INSERT, $urandom, $urandom);
		send_op(ACT_INSERT, $urandom, $urandom);
		send_op(ACT_INSERT, $urandom, $urandom);
		send_op(ACT_CLEAR, 32'd0, 32'd0);
	endtask

	// inserts and operations on live entries, some noise and clears
	task automatic test_random(int count);
		int pick;
		int k;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			k = live_keys.size() ? $urandom_range(0, live_keys.size() - 1) : 0;
			if (pick < 40 || live_keys.size() == 0)
				send_op(ACT_INSERT, $urandom_range(0, 3) ? $urandom_range(0, 63) : $urandom,
					$urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom);
			else if (pick < 65)
				send_op(ACT_FIND, live_keys[k], live_vals[k]);
			else if (pick < 85) begin
				send_op(ACT_DELETE, live_keys[k], live_vals[k]);
				live_keys.delete(k);
				live_vals.delete(k);
			end else if (pick < 99)
				send_op(action_t'($urandom_range(0, 2)), $urandom, $urandom);
			else
				send_op(ACT_CLEAR, $urandom, $urandom);
		end
	endtask

	initial begin
		fail_count = 0;
		tbl_buckets = CFG_RESET;
		table_wipe();
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_FIND;
		key_hash = '0;
		entry_data = '0;
		cfg_valid = 1'b0;
		bucket_count = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_pool_full();
		test_random(500);
		set_buckets(11'd1);
		test_random(300);
		set_buckets(11'd0);
		test_random(100);
		set_buckets(11'd1024);
		test_random(300);
		set_buckets(11'h7FF);
		test_random(100);
		set_buckets(11'd7);
		test_random(300);
		while (status_due.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("chained_hash_table_pool_core_tb: clean");
		else
			$display("chained_hash_table_pool_core_tb: errors");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("chained_hash_table_pool_core_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/chtp_pkg.sv
sv/chtp_mod_unit.sv
sv/chtp_ctrl.sv
sv/chained_hash_table_pool_core.sv
sv/chtp_checker.sv
test/chained_hash_table_pool_core_tb.sv
